[sv/bsed_pkg.sv]
// bsed_pkg: shared constants and types for the backslash escape decoder
// no dependencies; used by bsed_decode, backslash_escape_decoder and the testbench

package bsed_pkg;

    localparam int BYTE_W   = 8;
    localparam int GROUP_N  = 3;
    localparam int COUNT_W  = 2;

    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LOWER_N   = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_LOWER_T   = 8'h74;
    localparam logic [BYTE_W-1:0] CH_LOWER_R   = 8'h72;
    localparam logic [BYTE_W-1:0] CH_LOWER_X   = 8'h78;
    localparam logic [BYTE_W-1:0] CH_ZERO      = 8'h30;
    localparam logic [BYTE_W-1:0] CH_SEVEN     = 8'h37;
    localparam logic [BYTE_W-1:0] CH_NINE      = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LOWER_A   = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOWER_F   = 8'h66;
    localparam logic [BYTE_W-1:0] CH_UPPER_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_F   = 8'h46;

    // configuration register indexes
    localparam logic REG_ESCAPE_ENABLE  = 1'b0;
    localparam logic REG_APPEND_NEWLINE = 1'b1;

    // result bytes caused by one input request
    typedef struct packed {
        logic [GROUP_N-1:0][BYTE_W-1:0] bytes;
        logic [COUNT_W-1:0]             count;
        logic                           last;
    } bsed_group_t;

endpackage

[sv/bsed_decode.sv]
// bsed_decode: escape state machine, turns one input request into up to three bytes
// depends on bsed_pkg

module bsed_decode (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic                      escape_enable,
    input  logic                      append_newline,
    input  logic [7:0]                in_byte,
    input  logic                      in_last,
    output bsed_pkg::bsed_group_t     group
);
    import bsed_pkg::*;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_HEX,
        MODE_OCT
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic [BYTE_W-1:0]  value_reg, value_next;
    logic [COUNT_W-1:0] digits_reg, digits_next;

    logic               is_hex;
    logic [3:0]         hex_digit;
    logic               is_oct;

    always_comb
    begin
        is_hex    = 1'b1;
        hex_digit = in_byte[3:0];
        if (in_byte >= CH_ZERO && in_byte <= CH_NINE)
        begin
            hex_digit = in_byte[3:0];
        end
        else if ((in_byte >= CH_LOWER_A && in_byte <= CH_LOWER_F) ||
                 (in_byte >= CH_UPPER_A && in_byte <= CH_UPPER_F))
        begin
            hex_digit = in_byte[3:0] + 4'd9;
        end
        else
        begin
            is_hex = 1'b0;
        end
        is_oct = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
    end

    always_comb
    begin
        logic               plain;
        logic [COUNT_W-1:0] n;
        logic [GROUP_N-1:0][BYTE_W-1:0] bytes;

        plain       = 1'b1;
        n           = '0;
        bytes       = '0;
        mode_next   = mode_reg;
        value_next  = value_reg;
        digits_next = digits_reg;

        if (!escape_enable)
        begin
            mode_next   = MODE_NORMAL;
            value_next  = '0;
            digits_next = '0;
            bytes[n]    = in_byte;
            n           = n + 2'd1;
            plain       = 1'b0;
        end
        else
        begin
            case (mode_reg)
                MODE_HEX, MODE_OCT:
                begin
                    if ((mode_reg == MODE_HEX && is_hex) || (mode_reg == MODE_OCT && is_oct))
                    begin
                        plain       = 1'b0;
                        digits_next = digits_reg + 2'd1;
                        if (mode_reg == MODE_HEX)
                        begin
                            value_next = {value_reg[3:0], hex_digit};
                        end
                        else
                        begin
                            value_next = {value_reg[4:0], in_byte[2:0]};
                        end
                        if (digits_next == 2'd2)
                        begin
                            bytes[n]    = value_next;
                            n           = n + 2'd1;
                            mode_next   = MODE_NORMAL;
                            value_next  = '0;
                            digits_next = '0;
                        end
                    end
                    else
                    begin
                        bytes[n]    = value_reg;
                        n           = n + 2'd1;
                        mode_next   = MODE_NORMAL;
                        value_next  = '0;
                        digits_next = '0;
                    end
                end
                MODE_ESC:
                begin
                    plain       = 1'b0;
                    mode_next   = MODE_NORMAL;
                    value_next  = '0;
                    digits_next = '0;
                    if (in_byte == CH_LOWER_N)
                    begin
                        bytes[n] = CH_NEWLINE;
                        n        = n + 2'd1;
                    end
                    else if (in_byte == CH_LOWER_T)
                    begin
                        bytes[n] = CH_TAB;
                        n        = n + 2'd1;
                    end
                    else if (in_byte == CH_LOWER_R)
                    begin
                        bytes[n] = CH_CR;
                        n        = n + 2'd1;
                    end
                    else if (in_byte == CH_LOWER_X)
                    begin
                        mode_next = MODE_HEX;
                    end
                    else if (in_byte == CH_ZERO)
                    begin
                        mode_next = MODE_OCT;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (plain)
        begin
            if (in_byte == CH_BACKSLASH)
            begin
                mode_next = MODE_ESC;
            end
            else
            begin
                bytes[n] = in_byte;
                n        = n + 2'd1;
            end
        end

        if (in_last)
        begin
            if (mode_next == MODE_HEX || mode_next == MODE_OCT)
            begin
                bytes[n] = value_next;
                n        = n + 2'd1;
            end
            mode_next   = MODE_NORMAL;
            value_next  = '0;
            digits_next = '0;
            if (append_newline)
            begin
                bytes[n] = CH_NEWLINE;
                n        = n + 2'd1;
            end
        end

        group.bytes = bytes;
        group.count = n;
        group.last  = in_last && (n != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            value_reg  <= '0;
            digits_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            value_reg  <= value_next;
            digits_reg <= digits_next;
        end
    end

endmodule

[sv/backslash_escape_decoder.sv]
// channel   direction  handshake            payload
// in        request in valid / stall        in_byte, in_last
// out       result out valid / stall        out_byte, out_last
// cfg       write in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// one input request is decoded in the cycle it is accepted; its bytes (0 to 3) sit in a
// result register and leave one per cycle when not stalled, so the output port sets the pace
// a new request is taken whenever at most one result byte is still waiting and it leaves
// reset clears the decode state, result count and last flag; escape_enable 0, append_newline 1
// cfg writes are always ready and take effect on the next request
// depends on bsed_pkg and bsed_decode

module backslash_escape_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic       cfg_data
);
    import bsed_pkg::*;

    logic               escape_enable_reg;
    logic               append_newline_reg;
    logic [GROUP_N-1:0][BYTE_W-1:0] bytes_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               last_reg;

    bsed_group_t        group;
    logic               in_accept;
    logic               out_accept;

    assign cfg_ready  = 1'b1;
    assign out_valid  = (count_reg != '0);
    assign out_byte   = bytes_reg[0];
    assign out_last   = last_reg && (count_reg == 2'd1);
    assign out_accept = out_valid && !out_stall;
    assign in_stall   = !((count_reg == '0) || ((count_reg == 2'd1) && !out_stall));
    assign in_accept  = in_valid && !in_stall;

    bsed_decode u_decode (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (in_accept),
        .escape_enable  (escape_enable_reg),
        .append_newline (append_newline_reg),
        .in_byte        (in_byte),
        .in_last        (in_last),
        .group          (group)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_enable_reg  <= 1'b0;
            append_newline_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ESCAPE_ENABLE:  escape_enable_reg  <= cfg_data;
                REG_APPEND_NEWLINE: append_newline_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            last_reg  <= 1'b0;
        end
        else if (in_accept)
        begin
            count_reg <= group.count;
            last_reg  <= group.last;
        end
        else if (out_accept)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    // result bytes, shifted toward slot 0 as they leave
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            bytes_reg <= group.bytes;
        end
        else if (out_accept)
        begin
            bytes_reg <= {{BYTE_W{1'b0}}, bytes_reg[GROUP_N-1:1]};
        end
    end

endmodule

[sv/bsed_checker.sv]
// bsed_checker: port-level assertions for backslash_escape_decoder, with its bind
// depends on backslash_escape_decoder port names

module bsed_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       out_last,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("stalled result changed");

    // a blocked result always blocks new requests
    a_stall_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("request accepted while result blocked");

    // with nothing pending the input is open
    a_empty_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result register");

    // configuration writes never wait
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("cfg write not ready");

endmodule

bind backslash_escape_decoder bsed_checker u_bsed_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

[verif/backslash_escape_decoder_tb.sv]
// backslash_escape_decoder_tb: self-checking testbench for the backslash escape decoder
// predicts the decoded byte stream per request and checks every result byte in order
// depends on bsed_pkg and backslash_escape_decoder
`timescale 1ns / 100ps

module backslash_escape_decoder_tb;
    import bsed_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [2:0] {MODE_NORMAL, MODE_ESCAPE, MODE_HEX, MODE_OCTAL} decode_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } decoded_byte_t;

    typedef logic [7:0] byte_seq_t[$];

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = REG_ESCAPE_ENABLE;
    logic       cfg_data = 1'b0;

    decoded_byte_t decoded_bytes_q[$];
    decoded_byte_t want_byte;
    int            mismatch_count = 0;
    int            idle_cycles = 0;
    int            rx_gap_left = 0;
    int            rx_hold_req = 0;
    int            rx_hold_left = 0;
    bit            no_idle = 1'b0;
    bit            tx_burst = 1'b0;

    decode_mode_t mode_m = MODE_NORMAL;
    logic [7:0]   value_m = 8'h00;
    logic [1:0]   digits_m = 2'd0;
    logic         escape_en_m = 1'b0;
    logic         newline_m = 1'b1;

    backslash_escape_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int draw_wait();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= CH_ZERO && b <= CH_NINE)
            return int'(b - CH_ZERO);
        if (b >= CH_LOWER_A && b <= CH_LOWER_F)
            return int'(b - CH_LOWER_A) + 10;
        if (b >= CH_UPPER_A && b <= CH_UPPER_F)
            return int'(b - CH_UPPER_A) + 10;
        return -1;
    endfunction

    function automatic void clear_escape_state();
        mode_m = MODE_NORMAL;
        value_m = 8'h00;
        digits_m = 2'd0;
    endfunction

    function automatic void decode_request(input logic [7:0] b, input logic last);
        logic [7:0]    outs[$];
        bit            plain;
        int            d;
        decoded_byte_t item;
        plain = 1'b1;
        if (!escape_en_m) begin
            clear_escape_state();
            outs.push_back(b);
            plain = 1'b0;
        end
        else if (mode_m == MODE_HEX) begin
            d = hex_digit(b);
            if (d >= 0) begin
                value_m = {value_m[3:0], d[3:0]};
                digits_m = digits_m + 2'd1;
                plain = 1'b0;
                if (digits_m >= 2'd2) begin
                    outs.push_back(value_m);
                    clear_escape_state();
                end
            end
            else begin
                outs.push_back(value_m);
                clear_escape_state();
            end
        end
        else if (mode_m == MODE_OCTAL) begin
            if (b >= CH_ZERO && b <= CH_SEVEN) begin
                value_m = {value_m[4:0], b[2:0]};
                digits_m = digits_m + 2'd1;
                plain = 1'b0;
                if (digits_m >= 2'd2) begin
                    outs.push_back(value_m);
                    clear_escape_state();
                end
            end
            else begin
                outs.push_back(value_m);
                clear_escape_state();
            end
        end
        else if (mode_m == MODE_ESCAPE) begin
            plain = 1'b0;
            clear_escape_state();
            if (b == CH_LOWER_N)
                outs.push_back(CH_NEWLINE);
            else if (b == CH_LOWER_T)
                outs.push_back(CH_TAB);
            else if (b == CH_LOWER_R)
                outs.push_back(CH_CR);
            else if (b == CH_LOWER_X)
                mode_m = MODE_HEX;
            else if (b == CH_ZERO)
                mode_m = MODE_OCTAL;
        end
        if (plain) begin
            if (b == CH_BACKSLASH)
                mode_m = MODE_ESCAPE;
            else
                outs.push_back(b);
        end
        if (last) begin
            if (mode_m == MODE_HEX || mode_m == MODE_OCTAL)
                outs.push_back(value_m);
            clear_escape_state();
            if (newline_m)
                outs.push_back(CH_NEWLINE);
        end
        foreach (outs[i]) begin
            item.data = outs[i];
            item.last = last && (i == outs.size() - 1);
            decoded_bytes_q.push_back(item);
        end
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_burst ? 0 : draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_byte <= b;
        in_last <= last;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_request(b, last);
        @(negedge clk);
    endtask

    task automatic send_bytes(input byte_seq_t seq, input bit last_at_end);
        foreach (seq[i])
            send_request(seq[i], last_at_end && (i == seq.size() - 1));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (decoded_bytes_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_config(input logic escape_en, input logic newline);
        for (int i = 0; i < 2; i++) begin
            cfg_index <= (i == 0) ? REG_ESCAPE_ENABLE : REG_APPEND_NEWLINE;
            cfg_data <= (i == 0) ? escape_en : newline;
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (i == 0)
                escape_en_m = escape_en;
            else
                newline_m = newline;
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
            return CH_ZERO + 8'(r);
        if (r < 16)
            return CH_LOWER_A + 8'(r - 10);
        return CH_UPPER_A + 8'(r - 16);
    endfunction

    function automatic byte_seq_t random_token();
        byte_seq_t tok;
        int        k;
        case ($urandom_range(0, 9))
            0, 1, 2: tok.push_back(8'($urandom_range(8'h20, 8'h7E)));
            3: begin
                tok.push_back(CH_BACKSLASH);
                k = $urandom_range(0, 2);
                tok.push_back(k == 0 ? CH_LOWER_N : (k == 1 ? CH_LOWER_T : CH_LOWER_R));
            end
            4: begin
                tok.push_back(CH_BACKSLASH);
                tok.push_back(8'($urandom_range(0, 255)));
            end
            5, 6: begin
                tok.push_back(CH_BACKSLASH);
                tok.push_back(CH_LOWER_X);
                k = $urandom_range(0, 3);
                repeat (k) tok.push_back(random_hex_char());
            end
            7, 8: begin
                tok.push_back(CH_BACKSLASH);
                tok.push_back(CH_ZERO);
                k = $urandom_range(0, 3);
                repeat (k) tok.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            default: tok.push_back(8'($urandom_range(0, 255)));
        endcase
        return tok;
    endfunction

    task automatic run_random(input int n_items);
        byte_seq_t tok;
        int        sent;
        sent = 0;
        while (sent < n_items) begin
            tok = random_token();
            foreach (tok[i]) begin
                send_request(tok[i], $urandom_range(0, 7) == 0);
                sent++;
            end
        end
    endtask

    task automatic test_passthrough_reset();
        send_bytes({8'h00, CH_BACKSLASH, 8'hFF}, 1'b1);
        settle();
    endtask

    task automatic test_control_escapes();
        set_config(1'b1, 1'b0);
        // unknown escape letter q is dropped
        send_bytes({CH_BACKSLASH, CH_LOWER_N, CH_BACKSLASH, CH_LOWER_T,
                    CH_BACKSLASH, CH_LOWER_R, CH_BACKSLASH, 8'h71}, 1'b0);
    endtask

    task automatic test_numeric_escapes();
        // hex 41, hex with no digits before g, octal max, octal cut short by 8,
        // then a trailing backslash that ends the stream with nothing to emit
        send_bytes({CH_BACKSLASH, CH_LOWER_X, 8'h34, 8'h31,
                    CH_BACKSLASH, CH_LOWER_X, 8'h67,
                    CH_BACKSLASH, CH_ZERO, CH_SEVEN, CH_SEVEN,
                    CH_BACKSLASH, CH_ZERO, 8'h38,
                    CH_BACKSLASH}, 1'b1);
        settle();
    endtask

    task automatic test_append_newline();
        set_config(1'b1, 1'b1);
        // pending hex value flushed by the last byte, then the newline
        send_bytes({CH_BACKSLASH, CH_LOWER_X, CH_UPPER_A}, 1'b1);
        settle();
    endtask

    task automatic test_random_streams();
        logic [1:0] settings[6] = '{2'b11, 2'b10, 2'b00, 2'b11, 2'b01, 2'b10};
        foreach (settings[i]) begin
            set_config(settings[i][1], settings[i][0]);
            run_random(30);
            settle();
        end
    endtask

    task automatic test_output_backpressure();
        set_config(1'b1, 1'b1);
        @(posedge clk);
        rx_hold_req = HOLD_CYCLES;
        @(negedge clk);
        tx_burst = 1'b1;
        run_random(30);
        tx_burst = 1'b0;
        settle();
    endtask

    task automatic test_back_to_back();
        set_config(1'b1, 1'b0);
        no_idle = 1'b1;
        run_random(30);
        settle();
        no_idle = 1'b0;
    endtask

    always @(negedge clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left > 0) begin
            out_stall <= 1'b1;
            rx_hold_left--;
        end
        else if (rx_gap_left > 0) begin
            out_stall <= 1'b1;
            rx_gap_left--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (decoded_bytes_q.size() == 0) begin
                $error("unexpected result: out_byte %h out_last %b", out_byte, out_last);
                mismatch_count++;
            end
            else begin
                want_byte = decoded_bytes_q.pop_front();
                if (out_byte !== want_byte.data) begin
                    $error("out_byte: expected %h, actual %h", want_byte.data, out_byte);
                    mismatch_count++;
                end
                if (out_last !== want_byte.last) begin
                    $error("out_last: expected %b, actual %b", want_byte.last, out_last);
                    mismatch_count++;
                end
            end
            rx_gap_left = draw_wait();
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_passthrough_reset();
        test_control_escapes();
        test_numeric_escapes();
        test_append_newline();
        test_random_streams();
        test_output_backpressure();
        test_back_to_back();
        settle();
        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && decoded_bytes_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[backslash_escape_decoder.f]
sv/bsed_pkg.sv
sv/bsed_decode.sv
sv/backslash_escape_decoder.sv
sv/bsed_checker.sv
verif/backslash_escape_decoder_tb.sv
